FILE: rtl/ppg_heart_rate_spo2_estimator_macros.svh
// Assertion macros shared by the RTL.
`ifndef PPG_HEART_RATE_SPO2_ESTIMATOR_MACROS_SVH
`define PPG_HEART_RATE_SPO2_ESTIMATOR_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold at every edge out of reset
`define PPGHRS_ASSERT_ALW(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) \
    else $error("check failed");

// ante implies cons in the same cycle
`define PPGHRS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("check failed");

// ante implies cons in the next cycle
`define PPGHRS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("check failed");

`else

`define PPGHRS_ASSERT_ALW(lbl, ck, rs, cond)
`define PPGHRS_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define PPGHRS_ASSERT_NXT(lbl, ck, rs, ante, cons)

`endif

`endif

FILE: rtl/ppghrs_pkg.sv
package ppghrs_pkg;

  localparam int HISTORY_DEPTH_DEF = 5;
  localparam int SAMPLE_BITS_DEF   = 18;
  localparam int INDEX_BITS_DEF    = 32;

  localparam int Y_BITS      = 48;
  localparam int COEF_BITS   = 32;
  localparam int MUL_A_BITS  = 32;
  localparam int MUL_B_BITS  = 25;
  localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
  localparam int ACC_BITS    = 60;
  localparam int RATIO_BITS  = 58;
  localparam int DVD_BITS    = RATIO_BITS + 16;
  localparam int DVS_BITS    = RATIO_BITS;
  localparam int QUO_BITS    = 20;
  localparam int CNT_BITS    = 7;
  localparam int AVG_BITS    = 24;
  localparam int CFG_BITS    = 18;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_GAP  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPM      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_THR = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HR_MIN   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HR_MAX   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPO2_MIN = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPO2_MAX = 3'd6;

  localparam logic signed [16:0] SPO2_CAP   = 17'sd25574;
  localparam logic signed [16:0] SPO2_FLOOR = -17'sd65536;

  typedef struct packed {
    logic clear;
    logic enable;
    logic to_hi;
  } mac_ctrl_t;

  typedef struct packed {
    logic                start;
    logic [CNT_BITS-1:0] count;
  } div_ctrl_t;

  typedef struct packed {
    logic                done;
    logic                ovf;
    logic [QUO_BITS-1:0] quo;
  } div_res_t;

  // bandpass feedback taps, Q30, oldest output first
  function automatic logic signed [COEF_BITS-1:0] coef_q30(input logic [1:0] idx);
    logic signed [COEF_BITS-1:0] c;
    case (idx)
      2'd0:    c = -32'sd184482140;
      2'd1:    c = 32'sd395850521;
      2'd2:    c = -32'sd1258223964;
      default: c = 32'sd2119355692;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/ppghrs_mac.sv
module ppghrs_mac (
  input  logic                                     clk,
  input  logic                                     rst,
  input  ppghrs_pkg::mac_ctrl_t                    ctrl,
  input  logic signed [ppghrs_pkg::MUL_A_BITS-1:0] a,
  input  logic signed [ppghrs_pkg::MUL_B_BITS-1:0] b,
  output logic signed [ppghrs_pkg::ACC_BITS-1:0]   acc_hi,
  output logic signed [ppghrs_pkg::ACC_BITS-1:0]   acc_lo
);
  import ppghrs_pkg::*;

  logic signed [PROD_BITS-1:0] prod;
  logic                        prod_valid;
  logic                        prod_hi;

  // product register, then accumulate
  always_ff @(posedge clk) begin
    prod    <= a * b;
    prod_hi <= ctrl.to_hi;
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      prod_valid <= 1'b0;
      acc_hi     <= '0;
      acc_lo     <= '0;
    end else begin
      prod_valid <= ctrl.enable;
      if (prod_valid) begin
        if (prod_hi) begin
          acc_hi <= acc_hi + ACC_BITS'(prod);
        end else begin
          acc_lo <= acc_lo + ACC_BITS'(prod);
        end
      end
    end
  end

endmodule

FILE: rtl/ppghrs_div.sv
module ppghrs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  ppghrs_pkg::div_ctrl_t             ctrl,
  input  logic [ppghrs_pkg::DVD_BITS-1:0]   dividend,
  input  logic [ppghrs_pkg::DVS_BITS-1:0]   divisor,
  output ppghrs_pkg::div_res_t              res
);
  import ppghrs_pkg::*;

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] cnt;
  logic [DVD_BITS-1:0] dvd;
  logic [DVS_BITS-1:0] dvs;
  logic [DVS_BITS-1:0] rem;
  logic [QUO_BITS-1:0] quo;
  logic                ovf;
  logic [DVS_BITS:0]   shifted;
  logic [DVS_BITS+1:0] diff;
  logic                geq;
  logic [DVS_BITS-1:0] rem_next;

  // one restoring step per cycle, dividend MSB first
  always_comb begin
    shifted  = {rem, dvd[DVD_BITS-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs};
    geq      = !diff[DVS_BITS+1];
    rem_next = geq ? diff[DVS_BITS-1:0] : shifted[DVS_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= ctrl.count;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient keeps its low bits; anything shifted out is sticky overflow
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      dvd <= {dvd[DVD_BITS-2:0], 1'b0};
      rem <= rem_next;
      quo <= {quo[QUO_BITS-2:0], geq};
      ovf <= ovf | quo[QUO_BITS-1];
    end
  end

  assign res.done = done;
  assign res.ovf  = ovf;
  assign res.quo  = quo;

endmodule

FILE: rtl/ppg_heart_rate_spo2_estimator.sv
// PPG heart-rate and SpO2 estimator.
// Input channel: sample_valid / sample_stall carry one red and one IR raw sample per
// transfer. Output channel: result_valid / result_stall carry heart_rate_q8, spo2_q8,
// beat_gap and ratio_invalid; a result appears only for samples that detect a beat.
// Configuration: cfg_write with cfg_index / cfg_data writes one register per cycle;
// the user must write only while the block is idle; the block does not enforce this.
// Timing: one sample at a time. Both bandpass filters run through one shared
// 32x25 multiply-accumulate (eight products per channel). A beat adds a rate
// pass and a ratio pass through one shared restoring divider, one quotient bit
// per cycle (rate 33 bits at default parameters, SpO2 ratio 74 bits), and the
// two averages use reciprocal multiplies on the MAC; a zero divisor or opposite
// signs skip the ratio pass.
// sample_stall is high from the transfer until the sample is finished.
// A finished result sits in the output register; the next sample is taken even if
// that result is still stalled, and only its own result waits for the register.
// Reset clears filter delay lines, histories, beat timing and restores register
// defaults; no clearing pass is needed.
module ppg_heart_rate_spo2_estimator #(
  parameter int HISTORY_DEPTH = ppghrs_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = ppghrs_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX_BITS    = ppghrs_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [SAMPLE_BITS-1:0]              red_sample,
  input  logic [SAMPLE_BITS-1:0]              ir_sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [15:0]                         heart_rate_q8,
  output logic [14:0]                         spo2_q8,
  output logic [15:0]                         beat_gap,
  output logic                                ratio_invalid,
  input  logic                                cfg_write,
  input  logic [ppghrs_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ppghrs_pkg::CFG_BITS-1:0]     cfg_data
);
  import ppghrs_pkg::*;
  `include "ppg_heart_rate_spo2_estimator_macros.svh"

  localparam int HD        = HISTORY_DEPTH;
  localparam int SB        = SAMPLE_BITS;
  localparam int IB        = INDEX_BITS;
  localparam int SLOT_BITS = (HD > 1) ? $clog2(HD) : 1;
  localparam int MAG_BITS  = RATIO_BITS - SB;
  localparam int XT_BITS   = SB + 3;
  localparam int RNUM_BITS = ((IB > 24) ? IB : 24) + 1;
  localparam int SOFF      = 65536 * HD + HD / 2;
  // reciprocal of the depth; exact for averaging sums below 2^24
  localparam int     RECIP_SHIFT = 28;
  localparam longint RECIP_L     = ((64'sd1 <<< RECIP_SHIFT) + HD - 1) / HD;

  // sequencer codes
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_FILT   = 5'd1;
  localparam logic [4:0] S_FDRAIN = 5'd2;
  localparam logic [4:0] S_COMB1  = 5'd3;
  localparam logic [4:0] S_COMB2  = 5'd4;
  localparam logic [4:0] S_DETECT = 5'd5;
  localparam logic [4:0] S_RATE   = 5'd6;
  localparam logic [4:0] S_RATE_W = 5'd7;
  localparam logic [4:0] S_RATIO  = 5'd8;
  localparam logic [4:0] S_NUM    = 5'd9;
  localparam logic [4:0] S_NDRAIN = 5'd10;
  localparam logic [4:0] S_NSUM   = 5'd11;
  localparam logic [4:0] S_DEN    = 5'd12;
  localparam logic [4:0] S_DDRAIN = 5'd13;
  localparam logic [4:0] S_DSUM   = 5'd14;
  localparam logic [4:0] S_RDIV_W = 5'd15;
  localparam logic [4:0] S_STORE  = 5'd16;
  localparam logic [4:0] S_SUM    = 5'd17;
  localparam logic [4:0] S_HDIV   = 5'd18;
  localparam logic [4:0] S_HDIV_W = 5'd19;
  localparam logic [4:0] S_SDIV   = 5'd20;
  localparam logic [4:0] S_SDIV_W = 5'd21;
  localparam logic [4:0] S_FINISH = 5'd22;

  logic [4:0] state;
  logic       chan;          // 0 red, 1 IR
  logic [2:0] step;

  // configuration
  logic [9:0]  min_gap_samples;
  logic [15:0] samples_per_minute;
  logic [17:0] peak_threshold;
  logic [7:0]  hr_min;
  logic [7:0]  hr_max;
  logic [6:0]  spo2_min;
  logic [6:0]  spo2_max;

  // filter state
  logic [SB-1:0]            xline [2][5];
  logic signed [Y_BITS-1:0] yline [2][5];
  logic [IB-1:0]            sample_index;
  logic [IB-1:0]            last_beat;

  // histories
  logic [15:0]        rate_hist [HD];
  logic signed [16:0] sat_hist  [HD];
  logic [SLOT_BITS-1:0] history_slot;
  logic [SLOT_BITS-1:0] sum_idx;

  // working registers
  logic signed [ACC_BITS-1:0] comb_t;
  logic [IB-1:0]              gap_r;
  logic [15:0]                rate_r;
  logic [MAG_BITS-1:0]        ar_r;
  logic [MAG_BITS-1:0]        ai_r;
  logic [RATIO_BITS-1:0]      num_r;
  logic signed [16:0]         spo2_r;
  logic                       bad_r;
  logic [AVG_BITS-1:0]        hsum;
  logic signed [AVG_BITS-1:0] ssum;
  logic [15:0]                hr_r;

  // output register
  logic [15:0] hr_out;
  logic [14:0] spo2_out;
  logic [15:0] gap_out;
  logic        bad_out;

  // shared units
  mac_ctrl_t                  mac_ctrl;
  logic signed [MUL_A_BITS-1:0] mul_a;
  logic signed [MUL_B_BITS-1:0] mul_b;
  logic signed [ACC_BITS-1:0] acc_hi;
  logic signed [ACC_BITS-1:0] acc_lo;
  div_ctrl_t                  div_ctrl;
  logic [DVD_BITS-1:0]        div_dvd;
  logic [DVS_BITS-1:0]        div_dvs;
  div_res_t                   div_res;

  // combinational helpers
  logic [2:0]                 tap;
  logic signed [Y_BITS-1:0]   ysel;
  logic signed [XT_BITS-1:0]  xterm;
  logic signed [ACC_BITS-1:0] ysum;
  logic signed [Y_BITS-1:0]   y_sat;
  logic signed [Y_BITS-1:0]   thr_neg;
  logic [IB-1:0]              gap;
  logic                       beat;
  logic [RNUM_BITS-1:0]       rnum;
  logic [Y_BITS-1:0]          mag_red;
  logic [Y_BITS-1:0]          mag_ir;
  logic [MAG_BITS-1:0]        ar_cap;
  logic [MAG_BITS-1:0]        ai_cap;
  logic [RATIO_BITS-1:0]      prod_sum;
  logic [24:0]                q25;
  logic [24:0]                t_sum;
  logic signed [17:0]         v_spo2;
  logic signed [16:0]         spo2_calc;
  logic [AVG_BITS-1:0]        havg_dvd;
  logic [AVG_BITS-1:0]        savg_dvd;
  logic [QUO_BITS-1:0]        hquo;
  logic [QUO_BITS-1:0]        squo;
  logic signed [20:0]         savg;
  logic [14:0]                spo2_avg;
  logic [SLOT_BITS-1:0]       slot_next;

  ppghrs_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .a      (mul_a),
    .b      (mul_b),
    .acc_hi (acc_hi),
    .acc_lo (acc_lo)
  );

  ppghrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .res      (div_res)
  );

  // filter datapath: feedback taps split into signed top and unsigned bottom halves
  always_comb begin
    tap   = {1'b0, step[2:1]};
    ysel  = yline[chan][tap];
    xterm = $signed({3'b000, xline[chan][4]}) + $signed({3'b000, xline[chan][0]})
          - $signed({2'b00, xline[chan][2], 1'b0});
    ysum  = (ACC_BITS'(xterm) <<< 16) + (comb_t >>> 6);
    if (ysum[ACC_BITS-1:Y_BITS-1] == '0 || ysum[ACC_BITS-1:Y_BITS-1] == '1) begin
      y_sat = ysum[Y_BITS-1:0];
    end else if (ysum[ACC_BITS-1]) begin
      y_sat = {1'b1, {(Y_BITS-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(Y_BITS-1){1'b1}}};
    end
  end

  // beat test on the IR output, and the rate numerator
  always_comb begin
    thr_neg = Y_BITS'(-$signed({1'b0, peak_threshold, 16'h0000}));
    gap     = sample_index - last_beat;
    beat    = (yline[1][4] <= thr_neg) && (yline[1][2] < yline[1][0])
           && (yline[1][2] < yline[1][4]) && (gap > IB'(min_gap_samples));
    rnum    = RNUM_BITS'({samples_per_minute, 8'h00}) + RNUM_BITS'(gap_r >> 1);
  end

  // ratio magnitudes, capped, and the product sum from both accumulators
  always_comb begin
    mag_red = yline[0][4][Y_BITS-1] ? Y_BITS'(-yline[0][4]) : Y_BITS'(yline[0][4]);
    mag_ir  = yline[1][4][Y_BITS-1] ? Y_BITS'(-yline[1][4]) : Y_BITS'(yline[1][4]);
    ar_cap  = (|mag_red[Y_BITS-1:MAG_BITS]) ? '1 : mag_red[MAG_BITS-1:0];
    ai_cap  = (|mag_ir[Y_BITS-1:MAG_BITS]) ? '1 : mag_ir[MAG_BITS-1:0];
    prod_sum = RATIO_BITS'(acc_hi <<< 24) + RATIO_BITS'(acc_lo);
  end

  // SpO2 from the 4.16 ratio: 110 - 25 R, capped and floored; then the averaging helpers
  always_comb begin
    q25    = ({5'b0, div_res.quo} << 4) + ({5'b0, div_res.quo} << 3) + {5'b0, div_res.quo};
    t_sum  = q25 + 25'd128;
    v_spo2 = 18'sd28160 - $signed({1'b0, t_sum[24:8]});
    if (div_res.ovf || div_res.quo[QUO_BITS-1:16] == 4'hF) begin
      spo2_calc = SPO2_FLOOR;
    end else if (v_spo2 > 18'sd25600) begin
      spo2_calc = SPO2_CAP;
    end else if (v_spo2 < -18'sd65536) begin
      spo2_calc = SPO2_FLOOR;
    end else begin
      spo2_calc = v_spo2[16:0];
    end
    havg_dvd  = hsum + AVG_BITS'(HD / 2);
    savg_dvd  = AVG_BITS'(ssum) + AVG_BITS'(SOFF);
    // averages: rate sum in acc_hi, offset SpO2 sum in acc_lo, both scaled
    hquo      = acc_hi[RECIP_SHIFT +: QUO_BITS];
    squo      = acc_lo[RECIP_SHIFT +: QUO_BITS];
    savg      = $signed({1'b0, squo}) - 21'sd65536;
    if (savg < $signed({6'b0, spo2_min, 8'h00}) || savg > $signed({6'b0, spo2_max, 8'h00})) begin
      spo2_avg = '0;
    end else begin
      spo2_avg = savg[14:0];
    end
    slot_next = (history_slot == SLOT_BITS'(HD - 1)) ? '0 : history_slot + 1'b1;
  end

  // shared unit operand and control selection
  always_comb begin
    mac_ctrl = '0;
    mul_a    = '0;
    mul_b    = '0;
    div_ctrl = '0;
    div_dvd  = '0;
    div_dvs  = '0;
    unique case (state)
      S_IDLE, S_COMB2, S_RATIO, S_NSUM, S_STORE: begin
        mac_ctrl.clear = 1'b1;
      end
      S_FILT: begin
        mac_ctrl.enable = 1'b1;
        mac_ctrl.to_hi  = !step[0];
        mul_a = coef_q30(step[1:0] == 2'b00 ? step[2:1] : step[2:1]);
        mul_b = step[0] ? $signed({1'b0, ysel[23:0]})
                        : $signed({ysel[Y_BITS-1], ysel[Y_BITS-1:24]});
      end
      S_NUM, S_DEN: begin
        mac_ctrl.enable = 1'b1;
        mac_ctrl.to_hi  = !step[0];
        mul_a = (state == S_NUM) ? MUL_A_BITS'(xline[1][4]) : MUL_A_BITS'(xline[0][4]);
        if (state == S_NUM) begin
          mul_b = step[0] ? MUL_B_BITS'(ar_r[23:0]) : MUL_B_BITS'(ar_r[MAG_BITS-1:24]);
        end else begin
          mul_b = step[0] ? MUL_B_BITS'(ai_r[23:0]) : MUL_B_BITS'(ai_r[MAG_BITS-1:24]);
        end
      end
      S_RATE: begin
        div_ctrl.start = 1'b1;
        div_ctrl.count = CNT_BITS'(RNUM_BITS);
        div_dvd = DVD_BITS'(rnum) << (DVD_BITS - RNUM_BITS);
        div_dvs = DVS_BITS'(gap_r);
      end
      S_DSUM: begin
        div_ctrl.start = 1'b1;
        div_ctrl.count = CNT_BITS'(DVD_BITS);
        div_dvd = {num_r, 16'h0000};
        div_dvs = prod_sum;
      end
      S_HDIV: begin
        mac_ctrl.enable = 1'b1;
        mac_ctrl.to_hi  = 1'b1;
        mul_a = MUL_A_BITS'(RECIP_L);
        mul_b = $signed({1'b0, havg_dvd});
      end
      S_SDIV: begin
        mac_ctrl.enable = 1'b1;
        mac_ctrl.to_hi  = 1'b0;
        mul_a = MUL_A_BITS'(RECIP_L);
        mul_b = $signed({1'b0, savg_dvd});
      end
      default: begin
        mac_ctrl = '0;
      end
    endcase
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      chan               <= 1'b0;
      step               <= '0;
      sample_index       <= '0;
      last_beat          <= '0;
      history_slot       <= '0;
      sum_idx            <= '0;
      result_valid       <= 1'b0;
      min_gap_samples    <= 10'd50;
      samples_per_minute <= 16'd6000;
      peak_threshold     <= 18'd348;
      hr_min             <= 8'd40;
      hr_max             <= 8'd150;
      spo2_min           <= 7'd50;
      spo2_max           <= 7'd101;
      for (int c = 0; c < 2; c++) begin
        for (int j = 0; j < 5; j++) begin
          xline[c][j] <= '0;
          yline[c][j] <= '0;
        end
      end
      for (int h = 0; h < HD; h++) begin
        rate_hist[h] <= '0;
        sat_hist[h]  <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MIN_GAP:  min_gap_samples    <= cfg_data[9:0];
          REG_SPM:      samples_per_minute <= cfg_data[15:0];
          REG_PEAK_THR: peak_threshold     <= cfg_data[17:0];
          REG_HR_MIN:   hr_min             <= cfg_data[7:0];
          REG_HR_MAX:   hr_max             <= cfg_data[7:0];
          REG_SPO2_MIN: spo2_min           <= cfg_data[6:0];
          REG_SPO2_MAX: spo2_max           <= cfg_data[6:0];
          default: ;
        endcase
      end

      // in S_FINISH the output register load decides result_valid
      if (result_valid && !result_stall && state != S_FINISH) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            for (int c = 0; c < 2; c++) begin
              for (int j = 0; j < 4; j++) begin
                xline[c][j] <= xline[c][j+1];
                yline[c][j] <= yline[c][j+1];
              end
            end
            xline[0][4] <= red_sample;
            xline[1][4] <= ir_sample;
            chan  <= 1'b0;
            step  <= '0;
            state <= S_FILT;
          end
        end
        S_FILT: begin
          step <= step + 1'b1;
          if (step == 3'd7) begin
            state <= S_FDRAIN;
          end
        end
        S_FDRAIN: state <= S_COMB1;
        S_COMB1: begin
          comb_t <= acc_hi + (acc_lo >>> 24) + ACC_BITS'(32);
          state  <= S_COMB2;
        end
        S_COMB2: begin
          yline[chan][4] <= y_sat;
          if (!chan) begin
            chan  <= 1'b1;
            step  <= '0;
            state <= S_FILT;
          end else begin
            state <= S_DETECT;
          end
        end
        S_DETECT: begin
          gap_r        <= gap;
          sample_index <= sample_index + 1'b1;
          if (beat) begin
            last_beat <= sample_index;
            state     <= S_RATE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RATE: state <= S_RATE_W;
        S_RATE_W: begin
          if (div_res.done) begin
            rate_r <= (div_res.ovf || |div_res.quo[QUO_BITS-1:16]) ? 16'hFFFF
                                                                  : div_res.quo[15:0];
            state  <= S_RATIO;
          end
        end
        S_RATIO: begin
          bad_r <= 1'b0;
          ar_r  <= ar_cap;
          ai_r  <= ai_cap;
          step  <= '0;
          if (xline[0][4] == '0 || yline[1][4] == '0) begin
            bad_r  <= 1'b1;
            spo2_r <= '0;
            state  <= S_STORE;
          end else if (yline[0][4] != '0 && yline[0][4][Y_BITS-1] != yline[1][4][Y_BITS-1]) begin
            spo2_r <= SPO2_CAP;
            state  <= S_STORE;
          end else begin
            state <= S_NUM;
          end
        end
        S_NUM: begin
          step <= step + 1'b1;
          if (step == 3'd1) begin
            state <= S_NDRAIN;
          end
        end
        S_NDRAIN: state <= S_NSUM;
        S_NSUM: begin
          num_r <= prod_sum;
          step  <= '0;
          state <= S_DEN;
        end
        S_DEN: begin
          step <= step + 1'b1;
          if (step == 3'd1) begin
            state <= S_DDRAIN;
          end
        end
        S_DDRAIN: state <= S_DSUM;
        S_DSUM:   state <= S_RDIV_W;
        S_RDIV_W: begin
          if (div_res.done) begin
            spo2_r <= spo2_calc;
            state  <= S_STORE;
          end
        end
        S_STORE: begin
          rate_hist[history_slot] <= rate_r;
          sat_hist[history_slot]  <= spo2_r;
          history_slot <= slot_next;
          hsum         <= '0;
          ssum         <= '0;
          sum_idx      <= '0;
          state        <= S_SUM;
        end
        S_SUM: begin
          hsum    <= hsum + AVG_BITS'(rate_hist[sum_idx]);
          ssum    <= ssum + AVG_BITS'(sat_hist[sum_idx]);
          sum_idx <= sum_idx + 1'b1;
          if (sum_idx == SLOT_BITS'(HD - 1)) begin
            state <= S_HDIV;
          end
        end
        S_HDIV:   state <= S_HDIV_W;
        S_HDIV_W: state <= S_SDIV;
        S_SDIV: begin
          if (hquo < {4'h0, hr_min, 8'h00} || hquo > {4'h0, hr_max, 8'h00}) begin
            hr_r <= '0;
          end else begin
            hr_r <= hquo[15:0];
          end
          state <= S_SDIV_W;
        end
        S_SDIV_W: state <= S_FINISH;
        S_FINISH: begin
          // wait for the output register to be free
          if (!result_valid || !result_stall) begin
            hr_out       <= hr_r;
            spo2_out     <= spo2_avg;
            gap_out      <= (gap_r > IB'(16'hFFFF)) ? 16'hFFFF : gap_r[15:0];
            bad_out      <= bad_r;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample_stall  = (state != S_IDLE);
  assign heart_rate_q8 = hr_out;
  assign spo2_q8       = spo2_out;
  assign beat_gap      = gap_out;
  assign ratio_invalid = bad_out;

  `PPGHRS_ASSERT_NXT(a_accept_busy, clk, rst, sample_valid && !sample_stall, state != S_IDLE)
  `PPGHRS_ASSERT_ALW(a_slot_range, clk, rst, history_slot <= SLOT_BITS'(HD - 1))
  `PPGHRS_ASSERT_NXT(a_finish_loads, clk, rst, state == S_FINISH && !(result_valid && result_stall), result_valid && state == S_IDLE)
  `PPGHRS_ASSERT_IMP(a_div_waited, clk, rst, div_res.done, state == S_RATE_W || state == S_RDIV_W)

endmodule
